// ----- rtl/fffa_pkg.sv -----
// Shared definitions for the free-list frame allocator: field widths, status
// and request codes, register indexes and configuration port sizing.
// No dependencies.
package fffa_pkg;

   localparam int unsigned FRAMES_DEFAULT    = 4096;
   localparam int unsigned PAGE_BITS_DEFAULT = 20;

   localparam int unsigned COUNT_W      = 13;
   localparam int unsigned PAGE_COUNT_W = 8;
   localparam int unsigned STATUS_W     = 2;
   localparam int unsigned REG_INDEX_W  = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX       = 13'd8191;
   localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = 13'd4096;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OOM = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD = 2'd2;

   localparam logic [REG_INDEX_W-1:0] REG_FIRST_PAGE      = 2'd0;
   localparam logic [REG_INDEX_W-1:0] REG_FRAME_COUNT     = 2'd1;
   localparam logic [REG_INDEX_W-1:0] REG_RESERVED_FRAMES = 2'd2;

   function automatic int unsigned csr_data_w(input int unsigned page_bits);
      return (page_bits > 32) ? 64 : 32;
   endfunction

   function automatic int unsigned csr_addr_w(input int unsigned page_bits);
      return (page_bits > 32) ? 5 : 4;
   endfunction

endpackage

// ----- rtl/fffa_link_ram.sv -----
// Link memory of the free list: one next-frame index per frame, one write
// port and one read port with registered read data. Uses fffa_pkg.
module fffa_link_ram #(
   parameter int unsigned FRAMES = fffa_pkg::FRAMES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(FRAMES)-1:0] wr_addr,
   input  logic [$clog2(FRAMES)-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(FRAMES)-1:0] rd_addr,
   output logic [$clog2(FRAMES)-1:0] rd_data
);
   import fffa_pkg::*;

   localparam int unsigned IDX_W = $clog2(FRAMES);

   logic [IDX_W-1:0] link_ff [FRAMES];
   logic [IDX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= link_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/fffa_csr.sv -----
// Configuration registers of the frame allocator behind an APB-style port.
// Holds first page, frame count and reserved frame count. Uses fffa_pkg.
module fffa_csr #(
   parameter int unsigned PAGE_BITS = fffa_pkg::PAGE_BITS_DEFAULT
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              csr_psel,
   input  logic                                              csr_penable,
   input  logic                                              csr_pwrite,
   input  logic [fffa_pkg::csr_addr_w(PAGE_BITS)-1:0]        csr_paddr,
   input  logic [fffa_pkg::csr_data_w(PAGE_BITS)-1:0]        csr_pwdata,
   output logic [fffa_pkg::csr_data_w(PAGE_BITS)-1:0]        csr_prdata,
   output logic                                              csr_pready,
   output logic [PAGE_BITS-1:0]                              first_page,
   output logic [fffa_pkg::COUNT_W-1:0]                      frame_count,
   output logic [fffa_pkg::COUNT_W-1:0]                      reserved_frames
);
   import fffa_pkg::*;

   localparam int unsigned CSR_W    = csr_data_w(PAGE_BITS);
   localparam int unsigned ADDR_W   = csr_addr_w(PAGE_BITS);
   localparam int unsigned ADDR_LSB = ADDR_W - REG_INDEX_W;

   logic [PAGE_BITS-1:0]   first_page_ff;
   logic [COUNT_W-1:0]     frame_count_ff;
   logic [COUNT_W-1:0]     reserved_ff;
   logic [REG_INDEX_W-1:0] index;
   logic                   wr_en;

   assign index      = csr_paddr[ADDR_W-1:ADDR_LSB];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_page_ff  <= '0;
         frame_count_ff <= FRAME_COUNT_RST;
         reserved_ff    <= '0;
      end else if (wr_en) begin
         case (index)
            REG_FIRST_PAGE: begin
               first_page_ff <= csr_pwdata[PAGE_BITS-1:0];
            end
            REG_FRAME_COUNT: begin
               frame_count_ff <= csr_pwdata[COUNT_W-1:0];
            end
            REG_RESERVED_FRAMES: begin
               reserved_ff <= csr_pwdata[COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_FIRST_PAGE:      csr_prdata = CSR_W'(first_page_ff);
         REG_FRAME_COUNT:     csr_prdata = CSR_W'(frame_count_ff);
         REG_RESERVED_FRAMES: csr_prdata = CSR_W'(reserved_ff);
         default:             csr_prdata = '0;
      endcase
   end

   assign first_page      = first_page_ff;
   assign frame_count     = frame_count_ff;
   assign reserved_frames = reserved_ff;

endmodule

// ----- rtl/fffa_rsp_buf.sv -----
// Result word register of the frame allocator: holds one finished word
// until the consumer takes it. Uses fffa_pkg.
module fffa_rsp_buf #(
   parameter int unsigned PAGE_BITS = fffa_pkg::PAGE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [fffa_pkg::STATUS_W-1:0] status,
   input  logic [PAGE_BITS-1:0]          granted_page,
   input  logic [fffa_pkg::COUNT_W-1:0]  free_frames,
   output logic                          ready,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fffa_pkg::STATUS_W-1:0] rsp_status,
   output logic [PAGE_BITS-1:0]          rsp_granted_page,
   output logic [fffa_pkg::COUNT_W-1:0]  rsp_free_frames
);
   import fffa_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   logic [STATUS_W-1:0]  status_ff;
   logic [PAGE_BITS-1:0] grant_ff;
   logic [COUNT_W-1:0]   free_ff;

   assign ready    = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status;
         grant_ff  <= granted_page;
         free_ff   <= free_frames;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_granted_page = grant_ff;
   assign rsp_free_frames  = free_ff;

endmodule

// ----- rtl/fffa_engine.sv -----
// Allocation engine: classifies each request word, reads the link at the list
// head, then updates head, tail, count and fresh counter and writes the link
// memory. Uses fffa_pkg.
module fffa_engine #(
   parameter int unsigned FRAMES    = fffa_pkg::FRAMES_DEFAULT,
   parameter int unsigned PAGE_BITS = fffa_pkg::PAGE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_stall,
   input  logic                              in_type,
   input  logic [fffa_pkg::PAGE_COUNT_W-1:0] in_page_count,
   input  logic [PAGE_BITS-1:0]              in_page_number,
   input  logic [PAGE_BITS-1:0]              first_page,
   input  logic [fffa_pkg::COUNT_W-1:0]      frame_count,
   input  logic [fffa_pkg::COUNT_W-1:0]      reserved_frames,
   output logic                              mem_wr_en,
   output logic [$clog2(FRAMES)-1:0]         mem_wr_addr,
   output logic [$clog2(FRAMES)-1:0]         mem_wr_data,
   output logic                              mem_rd_en,
   output logic [$clog2(FRAMES)-1:0]         mem_rd_addr,
   input  logic [$clog2(FRAMES)-1:0]         mem_rd_data,
   input  logic                              out_ready,
   output logic                              out_load,
   output logic [fffa_pkg::STATUS_W-1:0]     out_status,
   output logic [PAGE_BITS-1:0]              out_granted_page,
   output logic [fffa_pkg::COUNT_W-1:0]      out_free_frames
);
   import fffa_pkg::*;

   localparam int unsigned IDX_W  = $clog2(FRAMES);
   localparam int unsigned LCNT_W = $clog2(FRAMES + 1);
   localparam int unsigned WIDE_W = ((LCNT_W > COUNT_W) ? LCNT_W : COUNT_W) + 1;
   localparam int unsigned CMP_W  = (PAGE_BITS > WIDE_W) ? PAGE_BITS : WIDE_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   localparam logic [2:0] K_FRESH = 3'd0;
   localparam logic [2:0] K_LIST  = 3'd1;
   localparam logic [2:0] K_OOM   = 3'd2;
   localparam logic [2:0] K_BAD   = 3'd3;
   localparam logic [2:0] K_FREE  = 3'd4;

   logic                 state_ff, state_in;
   logic [2:0]           kind_ff, kind_in;
   logic [IDX_W-1:0]     frame_ff;
   logic [PAGE_BITS-1:0] grant_ff, grant_in;
   logic [WIDE_W-1:0]    total_ff;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [LCNT_W-1:0]    lcount_ff, lcount_in;
   logic [COUNT_W-1:0]   fresh_ff, fresh_in;

   logic                 accept;
   logic                 commit;
   logic [WIDE_W-1:0]    eff_w;
   logic [WIDE_W-1:0]    next_w;
   logic                 fresh_avail;
   logic [WIDE_W-1:0]    fresh_left;
   logic [WIDE_W-1:0]    total_now;
   logic [PAGE_BITS-1:0] idx;
   logic [CMP_W-1:0]     idx_c;
   logic                 free_ok;
   logic [WIDE_W-1:0]    total_after;

   assign accept   = in_valid && (state_ff == ST_IDLE);
   assign in_stall = (state_ff != ST_IDLE);
   assign commit   = (state_ff == ST_EXEC) && out_ready;

   // Classification, done while the link at the head is being read.
   assign eff_w = (WIDE_W'(frame_count) > WIDE_W'(FRAMES)) ? WIDE_W'(FRAMES)
                                                          : WIDE_W'(frame_count);
   assign next_w      = WIDE_W'(reserved_frames) + WIDE_W'(fresh_ff);
   assign fresh_avail = next_w < eff_w;
   assign fresh_left  = fresh_avail ? (eff_w - next_w) : '0;
   assign total_now   = fresh_left + WIDE_W'(lcount_ff);
   assign idx         = in_page_number - first_page;
   assign idx_c       = CMP_W'(idx);
   assign free_ok     = (in_page_number >= first_page)
                     && (idx_c >= CMP_W'(reserved_frames))
                     && (idx_c < CMP_W'(eff_w))
                     && (lcount_ff != LCNT_W'(FRAMES));

   always_comb begin
      grant_in = '0;
      if (in_type == REQ_ALLOC) begin
         if (in_page_count != PAGE_COUNT_W'(1)) begin
            kind_in = K_BAD;
         end else if (fresh_avail) begin
            kind_in  = K_FRESH;
            grant_in = first_page + PAGE_BITS'(next_w);
         end else if (lcount_ff != '0) begin
            kind_in  = K_LIST;
            grant_in = first_page + PAGE_BITS'(head_ff);
         end else begin
            kind_in = K_OOM;
         end
      end else begin
         kind_in = free_ok ? K_FREE : K_BAD;
      end
   end

   assign mem_rd_en   = accept;
   assign mem_rd_addr = head_ff;

   // Commit: state update, link write-back and the result word.
   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      lcount_in   = lcount_ff;
      fresh_in    = fresh_ff;
      total_after = total_ff;
      mem_wr_en   = 1'b0;
      if (accept) begin
         state_in = ST_EXEC;
      end
      case (kind_ff)
         K_FRESH: begin
            total_after = total_ff - WIDE_W'(1);
            if (commit) begin
               fresh_in = fresh_ff + COUNT_W'(1);
            end
         end
         K_LIST: begin
            total_after = total_ff - WIDE_W'(1);
            if (commit) begin
               lcount_in = lcount_ff - LCNT_W'(1);
               if (lcount_ff > LCNT_W'(1)) begin
                  head_in = mem_rd_data;
               end
            end
         end
         K_FREE: begin
            total_after = total_ff + WIDE_W'(1);
            if (commit) begin
               lcount_in = lcount_ff + LCNT_W'(1);
               tail_in   = frame_ff;
               if (lcount_ff == '0) begin
                  head_in = frame_ff;
               end else begin
                  mem_wr_en = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      if (commit) begin
         state_in = ST_IDLE;
      end
   end

   assign mem_wr_addr = tail_ff;
   assign mem_wr_data = frame_ff;

   always_comb begin
      case (kind_ff)
         K_FRESH, K_LIST, K_FREE: out_status = STATUS_OK;
         K_OOM:                   out_status = STATUS_OOM;
         default:                 out_status = STATUS_BAD;
      endcase
   end

   assign out_load         = commit;
   assign out_granted_page = grant_ff;
   assign out_free_frames  = (total_after > WIDE_W'(COUNT_MAX)) ? COUNT_MAX
                                                               : COUNT_W'(total_after);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         tail_ff   <= '0;
         lcount_ff <= '0;
         fresh_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         lcount_ff <= lcount_in;
         fresh_ff  <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= kind_in;
         frame_ff <= IDX_W'(idx);
         grant_ff <= grant_in;
         total_ff <= total_now;
      end
   end

endmodule

// ----- rtl/fifo_free_list_frame_allocator_unit.sv -----
// Physical page-frame allocator with a FIFO free list; top level.
// Depends on fffa_pkg, fffa_csr, fffa_link_ram, fffa_engine and fffa_rsp_buf.
//
// Each request word is an allocate of one page or a free of one page, and
// gives exactly one result word. A request is handled in order: the link
// memory is read at the list head while the request is classified, then,
// once the result register can take the word, the head, tail, count and
// fresh counter are updated and the link memory is written back. A new
// word is taken only after the last one has committed, which waits while
// the result register is not drained. Never-used frames come out in
// ascending order before any freed frame; freed frames come back in the
// order they were freed. The link memory needs no clearing after reset, so
// the block accepts requests at once. The user must write configuration
// while no request is in flight; the block itself does not enforce this.
module fifo_free_list_frame_allocator_unit #(
   parameter int unsigned FRAMES           = fffa_pkg::FRAMES_DEFAULT,
   parameter int unsigned PAGE_NUMBER_BITS = fffa_pkg::PAGE_BITS_DEFAULT
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              req_valid,
   output logic                                              req_stall,
   input  logic                                              req_type,
   input  logic [fffa_pkg::PAGE_COUNT_W-1:0]                 req_page_count,
   input  logic [PAGE_NUMBER_BITS-1:0]                       req_page_number,
   output logic                                              rsp_valid,
   input  logic                                              rsp_stall,
   output logic [fffa_pkg::STATUS_W-1:0]                     rsp_status,
   output logic [PAGE_NUMBER_BITS-1:0]                       rsp_granted_page,
   output logic [fffa_pkg::COUNT_W-1:0]                      rsp_free_frames,
   input  logic                                              csr_psel,
   input  logic                                              csr_penable,
   input  logic                                              csr_pwrite,
   input  logic [fffa_pkg::csr_addr_w(PAGE_NUMBER_BITS)-1:0] csr_paddr,
   input  logic [fffa_pkg::csr_data_w(PAGE_NUMBER_BITS)-1:0] csr_pwdata,
   output logic [fffa_pkg::csr_data_w(PAGE_NUMBER_BITS)-1:0] csr_prdata,
   output logic                                              csr_pready
);
   import fffa_pkg::*;

   localparam int unsigned IDX_W = $clog2(FRAMES);

   logic [PAGE_NUMBER_BITS-1:0] first_page;
   logic [COUNT_W-1:0]          frame_count;
   logic [COUNT_W-1:0]          reserved_frames;

   logic                        mem_wr_en;
   logic [IDX_W-1:0]            mem_wr_addr;
   logic [IDX_W-1:0]            mem_wr_data;
   logic                        mem_rd_en;
   logic [IDX_W-1:0]            mem_rd_addr;
   logic [IDX_W-1:0]            mem_rd_data;

   logic                        out_ready;
   logic                        out_load;
   logic [STATUS_W-1:0]         out_status;
   logic [PAGE_NUMBER_BITS-1:0] out_granted_page;
   logic [COUNT_W-1:0]          out_free_frames;

   fffa_csr #(
      .PAGE_BITS (PAGE_NUMBER_BITS)
   ) u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .first_page      (first_page),
      .frame_count     (frame_count),
      .reserved_frames (reserved_frames)
   );

   fffa_link_ram #(
      .FRAMES (FRAMES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   fffa_engine #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_NUMBER_BITS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_valid),
      .in_stall         (req_stall),
      .in_type          (req_type),
      .in_page_count    (req_page_count),
      .in_page_number   (req_page_number),
      .first_page       (first_page),
      .frame_count      (frame_count),
      .reserved_frames  (reserved_frames),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_en        (mem_rd_en),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data),
      .out_ready        (out_ready),
      .out_load         (out_load),
      .out_status       (out_status),
      .out_granted_page (out_granted_page),
      .out_free_frames  (out_free_frames)
   );

   fffa_rsp_buf #(
      .PAGE_BITS (PAGE_NUMBER_BITS)
   ) u_rsp_buf (
      .clock            (clock),
      .reset            (reset),
      .load             (out_load),
      .status           (out_status),
      .granted_page     (out_granted_page),
      .free_frames      (out_free_frames),
      .ready            (out_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_granted_page (rsp_granted_page),
      .rsp_free_frames  (rsp_free_frames)
   );

endmodule

// ----- sim/fffa_outcome_check.sv -----
// Result checker for the free-list frame allocator: follows the register port,
// predicts each result word from accepted request words and compares them.
// Depends on fffa_pkg.
module fffa_outcome_check #(
   parameter int unsigned FRAMES    = fffa_pkg::FRAMES_DEFAULT,
   parameter int unsigned PAGE_BITS = fffa_pkg::PAGE_BITS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   input  logic                                       req_stall,
   input  logic                                       req_type,
   input  logic [fffa_pkg::PAGE_COUNT_W-1:0]          req_page_count,
   input  logic [PAGE_BITS-1:0]                       req_page_number,
   input  logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   input  logic [fffa_pkg::STATUS_W-1:0]              rsp_status,
   input  logic [PAGE_BITS-1:0]                       rsp_granted_page,
   input  logic [fffa_pkg::COUNT_W-1:0]               rsp_free_frames,
   input  logic                                       csr_psel,
   input  logic                                       csr_penable,
   input  logic                                       csr_pwrite,
   input  logic [fffa_pkg::csr_addr_w(PAGE_BITS)-1:0] csr_paddr,
   input  logic [fffa_pkg::csr_data_w(PAGE_BITS)-1:0] csr_pwdata,
   input  logic                                       csr_pready,
   output int                                         fail_count,
   output int                                         backlog
);
   timeunit 1ns;
   timeprecision 1ps;

   import fffa_pkg::*;

   localparam int unsigned REG_SHIFT = (csr_data_w(PAGE_BITS) > 32) ? 3 : 2;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [PAGE_BITS-1:0] page;
      logic [COUNT_W-1:0]   frames;
   } outcome_type;

   outcome_type          awaited[$];
   int                   errs = 0;

   logic [PAGE_BITS-1:0] base_page;
   logic [COUNT_W-1:0]   frame_limit;
   logic [COUNT_W-1:0]   held_frames;
   int unsigned          fresh_taken;
   int unsigned          list_first;
   int unsigned          list_last;
   int unsigned          list_len;
   int unsigned          link_mem[FRAMES];

   function automatic outcome_type grant_or_release(input logic kind,
                                                    input logic [PAGE_COUNT_W-1:0] cnt,
                                                    input logic [PAGE_BITS-1:0] page);
      outcome_type     o;
      longint unsigned span;
      longint unsigned next_fresh;
      longint unsigned offset;
      longint unsigned avail;
      span = (frame_limit > FRAMES) ? FRAMES : frame_limit;
      next_fresh = held_frames + fresh_taken;
      o = '0;
      o.status = STATUS_OK;
      if (kind == REQ_ALLOC) begin
         if (cnt != 1) begin
            o.status = STATUS_BAD;
         end else if (next_fresh < span) begin
            o.page = PAGE_BITS'(base_page + next_fresh);
            fresh_taken++;
         end else if (list_len > 0) begin
            o.page = PAGE_BITS'(base_page + list_first);
            if (list_len > 1) list_first = link_mem[list_first];
            list_len--;
         end else begin
            o.status = STATUS_OOM;
         end
      end else if (page < base_page) begin
         o.status = STATUS_BAD;
      end else begin
         offset = page - base_page;
         if (offset < held_frames || offset >= span || list_len >= FRAMES) begin
            o.status = STATUS_BAD;
         end else begin
            if (list_len == 0) list_first = offset;
            else link_mem[list_last] = offset;
            list_last = offset;
            list_len++;
         end
      end
      next_fresh = held_frames + fresh_taken;
      avail = ((next_fresh < span) ? span - next_fresh : 0) + list_len;
      o.frames = (avail > COUNT_MAX) ? COUNT_MAX : COUNT_W'(avail);
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         awaited.delete();
         base_page = '0;
         frame_limit = FRAME_COUNT_RST;
         held_frames = '0;
         fresh_taken = 0;
         list_first = 0;
         list_last = 0;
         list_len = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (REG_INDEX_W'(csr_paddr >> REG_SHIFT))
               REG_FIRST_PAGE:      base_page = csr_pwdata[PAGE_BITS-1:0];
               REG_FRAME_COUNT:     frame_limit = csr_pwdata[COUNT_W-1:0];
               REG_RESERVED_FRAMES: held_frames = csr_pwdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            awaited.push_back(grant_or_release(req_type, req_page_count, req_page_number));
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               $error("result word arrived with no request outstanding");
               errs++;
            end else begin
               want = awaited.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_status);
                  errs++;
               end
               if (rsp_granted_page !== want.page) begin
                  $error("granted_page expected %0h got %0h", want.page, rsp_granted_page);
                  errs++;
               end
               if (rsp_free_frames !== want.frames) begin
                  $error("free_frames expected %0d got %0d", want.frames, rsp_free_frames);
                  errs++;
               end
            end
         end
      end
      fail_count <= errs;
      backlog <= awaited.size();
   end

endmodule

// ----- sim/fifo_free_list_frame_allocator_unit_tb.sv -----
// Testbench top for the free-list frame allocator: clock, reset, request and
// register stimulus, and the verdict. Depends on fffa_pkg, the allocator RTL
// and fffa_outcome_check, which predicts and compares every result word.
module fifo_free_list_frame_allocator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fffa_pkg::*;

   localparam int unsigned FRAMES      = FRAMES_DEFAULT;
   localparam int unsigned PAGE_BITS   = PAGE_BITS_DEFAULT;
   localparam int unsigned ADDR_W      = csr_addr_w(PAGE_BITS);
   localparam int unsigned DATA_W      = csr_data_w(PAGE_BITS);
   localparam int unsigned REG_STEP    = (DATA_W > 32) ? 8 : 4;
   localparam int unsigned PAGE_TOP    = (1 << PAGE_BITS) - 1;
   localparam int unsigned RAND_PHASES = 8;
   localparam int unsigned PHASE_WORDS = 200;
   localparam int unsigned FILL_WORDS  = 200;
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_type;
   logic [PAGE_COUNT_W-1:0]    req_page_count;
   logic [PAGE_BITS-1:0]       req_page_number;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic [PAGE_BITS-1:0]       rsp_granted_page;
   logic [COUNT_W-1:0]         rsp_free_frames;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [ADDR_W-1:0]          csr_paddr;
   logic [DATA_W-1:0]          csr_pwdata;
   logic [DATA_W-1:0]          csr_prdata;
   logic                       csr_pready;

   int                         fail_count;
   int                         backlog;
   int unsigned                cycle_count = 0;
   int unsigned                words_sent = 0;
   int unsigned                send_idle_pct = 0;
   int unsigned                stall_pct = 0;
   int unsigned                cur_first = 0;
   int unsigned                cur_count = FRAMES;
   int unsigned                cur_reserved = 0;

   fifo_free_list_frame_allocator_unit #(
      .FRAMES           (FRAMES),
      .PAGE_NUMBER_BITS (PAGE_BITS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_page_count   (req_page_count),
      .req_page_number  (req_page_number),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_granted_page (rsp_granted_page),
      .rsp_free_frames  (rsp_free_frames),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   fffa_outcome_check #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) outcome_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_page_count   (req_page_count),
      .req_page_number  (req_page_number),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_granted_page (rsp_granted_page),
      .rsp_free_frames  (rsp_free_frames),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_pready       (csr_pready),
      .fail_count       (fail_count),
      .backlog          (backlog)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   task automatic issue_request(input logic kind, input logic [PAGE_COUNT_W-1:0] cnt,
                                input logic [PAGE_BITS-1:0] page);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_page_count <= cnt;
      req_page_number <= page;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic [REG_INDEX_W-1:0] idx, input int unsigned value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_W'(REG_STEP * idx);
      csr_pwdata <= DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic apply_layout(input int unsigned first, input int unsigned count,
                               input int unsigned reserved);
      settle();
      write_reg(REG_FIRST_PAGE, first);
      write_reg(REG_FRAME_COUNT, count);
      write_reg(REG_RESERVED_FRAMES, reserved);
      cur_first = first;
      cur_count = count;
      cur_reserved = reserved;
   endtask

   task automatic random_request();
      int unsigned             roll;
      logic [PAGE_COUNT_W-1:0] cnt;
      logic [PAGE_BITS-1:0]    page;
      roll = $urandom_range(99);
      cnt = PAGE_COUNT_W'($urandom);
      page = PAGE_BITS'($urandom);
      if (roll < 50) begin
         issue_request(REQ_ALLOC, PAGE_COUNT_W'(1), page);
      end else if (roll < 56) begin
         issue_request(REQ_ALLOC, (cnt == 1) ? PAGE_COUNT_W'(0) : cnt, page);
      end else if (roll < 90) begin
         if (cur_reserved < cur_count)
            page = PAGE_BITS'(cur_first + $urandom_range(cur_count - 1, cur_reserved));
         else
            page = PAGE_BITS'(cur_first + $urandom_range(cur_count + 7));
         issue_request(REQ_FREE, cnt, page);
      end else if (roll < 95 || cur_first == 0) begin
         issue_request(REQ_FREE, cnt, page);
      end else begin
         issue_request(REQ_FREE, cnt, PAGE_BITS'(cur_first - 1 - $urandom_range(cur_first - 1)));
      end
   endtask

   initial begin
      int unsigned p;
      int unsigned fp;
      int unsigned fc;
      int unsigned rs;
      int unsigned pick;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_type <= REQ_ALLOC;
      req_page_count <= '0;
      req_page_number <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue_request(REQ_ALLOC, PAGE_COUNT_W'(0), '0);
      issue_request(REQ_ALLOC, '1, '1);
      issue_request(REQ_ALLOC, PAGE_COUNT_W'(2), '0);
      issue_request(REQ_FREE, PAGE_COUNT_W'(1), PAGE_BITS'(FRAMES));
      issue_request(REQ_FREE, '0, '1);

      // Build a long free list before any fresh frame is used, then drain it
      // with the fresh frames reserved away, one allocate past empty.
      apply_layout(0, FRAMES, 0);
      repeat (FILL_WORDS)
         issue_request(REQ_FREE, PAGE_COUNT_W'($urandom), PAGE_BITS'($urandom_range(FRAMES - 1)));
      apply_layout(0, FRAMES, FRAMES);
      repeat (FILL_WORDS + 1) issue_request(REQ_ALLOC, PAGE_COUNT_W'(1), PAGE_BITS'($urandom));

      apply_layout(PAGE_TOP, 3, 1);
      repeat (3) issue_request(REQ_ALLOC, PAGE_COUNT_W'(1), '0);
      issue_request(REQ_FREE, PAGE_COUNT_W'(1), '1);
      issue_request(REQ_FREE, PAGE_COUNT_W'(1), '0);

      apply_layout(32'h100, FRAMES, FRAMES - 6);
      issue_request(REQ_FREE, PAGE_COUNT_W'(1), PAGE_BITS'(32'h100 + FRAMES - 1));
      issue_request(REQ_FREE, PAGE_COUNT_W'(1), PAGE_BITS'(32'h100 + FRAMES));
      issue_request(REQ_FREE, PAGE_COUNT_W'(1), PAGE_BITS'(32'h100 + FRAMES - 7));
      repeat (2) issue_request(REQ_FREE, PAGE_COUNT_W'(1), PAGE_BITS'(32'h100 + FRAMES - 6));

      apply_layout(32'h100, 8, 20);
      repeat (4) issue_request(REQ_ALLOC, PAGE_COUNT_W'(1), '0);
      issue_request(REQ_FREE, PAGE_COUNT_W'(1), PAGE_BITS'(32'h105));

      apply_layout(32'h2000, 1, 0);
      repeat (2) issue_request(REQ_ALLOC, PAGE_COUNT_W'(1), '0);
      issue_request(REQ_FREE, PAGE_COUNT_W'(1), PAGE_BITS'(32'h2000));
      issue_request(REQ_ALLOC, PAGE_COUNT_W'(1), '0);

      for (p = 0; p < RAND_PHASES; p++) begin
         pick = (p < 6) ? p : $urandom_range(5);
         case (pick)
            0: begin
               fc = 1;
               rs = 0;
            end
            1: begin
               fc = FRAMES;
               rs = 0;
            end
            2: begin
               fc = $urandom_range(64, 2);
               rs = fc;
            end
            3: begin
               fc = $urandom_range(64, 1);
               rs = $urandom_range(FRAMES, fc + 1);
            end
            default: begin
               fc = $urandom_range(64, 2);
               rs = $urandom_range(fc / 2);
            end
         endcase
         case ($urandom_range(3))
            0: fp = 0;
            1: fp = PAGE_TOP - $urandom_range(32);
            default: fp = $urandom_range(PAGE_TOP);
         endcase
         apply_layout(fp, fc, rs);
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 87;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 87;
            end
            default: begin
               send_idle_pct = 20;
               stall_pct = 20;
            end
         endcase
         repeat (PHASE_WORDS) random_request();
      end

      settle();
      $display("Sent %0d request words: malformed and out-of-range requests, a long free list",
               words_sent);
      $display("and its drain, wrapped page numbers, and %0d random layouts under mixed idling.",
               RAND_PHASES);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
